// ===== design/homogeneous_vector_transform_unit_assert.svh =====
// Assertion macros for the homogeneous vector transform unit.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef HOMOGENEOUS_VECTOR_TRANSFORM_UNIT_ASSERT_SVH
`define HOMOGENEOUS_VECTOR_TRANSFORM_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define HVT_CHECK(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hvt same-cycle check failed");
`define HVT_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hvt next-cycle check failed");
`else
`define HVT_CHECK(lbl, ante, cons)
`define HVT_CHECK_NEXT(lbl, ante, cons)
`endif

`endif

// ===== design/hvt_pkg.sv =====
`default_nettype none
package hvt_pkg;

	localparam int FIELD_W = 32;
	localparam int CW      = 32;
	localparam int FB      = 16;
	localparam int LANES   = 4;
	localparam int NREG    = 8;
	localparam int CFG_W   = 64;
	localparam int IDX_W   = 4;
	localparam int MIDX_W  = $clog2(NREG);

	// Product, exact sum of four products, and floored dot product widths.
	localparam int PW      = 2 * CW;
	localparam int SW      = PW + 2;
	localparam int DW      = SW - FB;
	// Quotient bits kept; anything at or above 2^QB is flagged as overflow.
	localparam int QB      = CW + 1;
	localparam int NW      = DW + FB;
	localparam int SH      = QB - FB;
	localparam int DIV_LAT = QB + 2;

	localparam logic CMD_FULL  = 1'b0;
	localparam logic CMD_POINT = 1'b1;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [DW-1:0] dot_t;
	typedef logic [DW-1:0]        mag_t;
	typedef logic [QB-1:0]        quo_t;

	localparam comp_t ONE_COMP = comp_t'(1) << FB;
	localparam dot_t  ONE_DOT  = dot_t'(1) << FB;
	localparam mag_t  ONE_MAG  = mag_t'(1) << FB;

	localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FB;
	localparam logic [CFG_W-1:0] ONE_HI = ONE_LO << (CFG_W / 2);
	localparam logic [CFG_W-1:0] REG_RESET [NREG] = '{
		ONE_HI, '0, ONE_LO, '0, '0, ONE_HI, '0, ONE_LO
	};

	typedef struct packed {
		logic                      cmd;
		logic signed [FIELD_W-1:0] in_x;
		logic signed [FIELD_W-1:0] in_y;
		logic signed [FIELD_W-1:0] in_z;
		logic signed [FIELD_W-1:0] in_w;
	} in_item_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] out_x;
		logic signed [FIELD_W-1:0] out_y;
		logic signed [FIELD_W-1:0] out_z;
		logic signed [FIELD_W-1:0] out_w;
		logic                      zero_scale;
		logic                      saturated;
	} out_item_t;

	typedef struct packed {
		logic neg;
		logic ovf;
		quo_t quo;
	} div_res_t;

	typedef struct packed {
		logic valid;
		logic point;
		logic zero;
	} ctl_t;

endpackage
`default_nettype wire

// ===== design/homogeneous_vector_transform_unit.sv =====
// Channel   Signals                          Payload
// input     in_valid / in_ready              in_data (cmd, in_x..in_w)
// output    out_valid / out_ready            out_data (out_x..out_w, flags)
// config    cfg_wr_en, cfg_index             cfg_data (one matrix register)
//
// One transaction is accepted per cycle while the output is not stalled.
// The divider yields one quotient bit per stage over 33 stages; it follows two
// dot-product stages and two setup stages, and the output register comes last.
// Every item takes the divider path; without a divide the divisor is 1.0.
// A stall at the output freezes the whole pipeline; in_ready follows it.
// Reset clears the valid flags and loads the identity matrix.
`default_nettype none
`include "homogeneous_vector_transform_unit_assert.svh"
module homogeneous_vector_transform_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  hvt_pkg::in_item_t             in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output hvt_pkg::out_item_t            out_data,
	input  logic                          cfg_wr_en,
	input  logic [hvt_pkg::IDX_W-1:0]     cfg_index,
	input  logic [hvt_pkg::CFG_W-1:0]     cfg_data
);
	import hvt_pkg::*;

	logic             adv;
	logic [CFG_W-1:0] mat_q [NREG];
	comp_t            vec [LANES];
	comp_t            rows [LANES][LANES];
	dot_t             dot_s2 [LANES];
	div_res_t         res [LANES];
	logic             use_scale;
	ctl_t             ctl_s1;
	ctl_t             ctl_s2;
	ctl_t             ctl_sd [DIV_LAT];
	out_item_t        merged;
	logic             out_valid_q;
	out_item_t        out_q;

	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREG; i++) begin
				mat_q[i] <= REG_RESET[i];
			end
		end else if (cfg_wr_en && (cfg_index < IDX_W'(NREG))) begin
			mat_q[cfg_index[MIDX_W-1:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < LANES; r++) begin
			rows[r][0] = comp_t'(mat_q[2*r][CFG_W-1 -: CW]);
			rows[r][1] = comp_t'(mat_q[2*r][CW-1:0]);
			rows[r][2] = comp_t'(mat_q[2*r+1][CFG_W-1 -: CW]);
			rows[r][3] = comp_t'(mat_q[2*r+1][CW-1:0]);
		end
		vec[0] = comp_t'(in_data.in_x[CW-1:0]);
		vec[1] = comp_t'(in_data.in_y[CW-1:0]);
		vec[2] = comp_t'(in_data.in_z[CW-1:0]);
		vec[3] = (in_data.cmd == CMD_POINT) ? ONE_COMP : comp_t'(in_data.in_w[CW-1:0]);
	end

	for (genvar r = 0; r < LANES; r++) begin : g_lane
		hvt_dot_lane u_dot (
			.clk    (clk),
			.en     (adv),
			.vec    (vec),
			.row    (rows[r]),
			.dot_s2 (dot_s2[r])
		);

		hvt_div_lane u_div (
			.clk       (clk),
			.en        (adv),
			.num       (dot_s2[r]),
			.scale     (dot_s2[LANES-1]),
			.use_scale (use_scale),
			.res       (res[r])
		);
	end

	// Row 3 is the homogeneous scale in point mode.
	assign use_scale = ctl_s2.point && (dot_s2[LANES-1] != ONE_DOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1      <= '0;
			ctl_s2      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < DIV_LAT; i++) begin
				ctl_sd[i] <= '0;
			end
		end else if (adv) begin
			ctl_s1    <= '{valid: in_valid, point: (in_data.cmd == CMD_POINT), zero: 1'b0};
			ctl_s2    <= ctl_s1;
			ctl_sd[0] <= '{valid: ctl_s2.valid, point: ctl_s2.point,
				zero: ctl_s2.point && (dot_s2[LANES-1] == '0)};
			for (int i = 1; i < DIV_LAT; i++) begin
				ctl_sd[i] <= ctl_sd[i-1];
			end
			out_valid_q <= ctl_sd[DIV_LAT-1].valid;
		end
	end

	hvt_merge u_merge (
		.res  (res),
		.ctl  (ctl_sd[DIV_LAT-1]),
		.item (merged)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= merged;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`HVT_CHECK(a_zero_scale_out, out_valid && out_data.zero_scale, out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0 && out_data.out_w == '0 && !out_data.saturated)
	`HVT_CHECK(a_point_w_zero, ctl_sd[DIV_LAT-1].valid && ctl_sd[DIV_LAT-1].point, merged.out_w == '0)
	`HVT_CHECK_NEXT(a_stall_freeze, !adv, $stable(ctl_s1) && $stable(ctl_s2))
	`HVT_CHECK_NEXT(a_out_load, adv && ctl_sd[DIV_LAT-1].valid, out_valid)

endmodule
`default_nettype wire

// ===== design/hvt_dot_lane.sv =====
`default_nettype none
module hvt_dot_lane (
	input  logic          clk,
	input  logic          en,
	input  hvt_pkg::comp_t vec [hvt_pkg::LANES],
	input  hvt_pkg::comp_t row [hvt_pkg::LANES],
	output hvt_pkg::dot_t  dot_s2
);
	import hvt_pkg::*;

	logic signed [PW-1:0] prod_s1 [LANES];
	logic signed [SW-1:0] sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				prod_s1[k] <= PW'(vec[k]) * PW'(row[k]);
			end
		end
	end

	always_comb begin
		sum = (SW'(prod_s1[0]) + SW'(prod_s1[1])) + (SW'(prod_s1[2]) + SW'(prod_s1[3]));
	end

	// Arithmetic shift floors toward minus infinity.
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= sum[SW-1:FB];
		end
	end

endmodule
`default_nettype wire

// ===== design/hvt_div_lane.sv =====
`default_nettype none
module hvt_div_lane (
	input  logic              clk,
	input  logic              en,
	input  hvt_pkg::dot_t     num,
	input  hvt_pkg::dot_t     scale,
	input  logic              use_scale,
	output hvt_pkg::div_res_t res
);
	import hvt_pkg::*;

	mag_t            n_s3;
	mag_t            d_s3;
	logic            neg_s3;
	logic [NW-1:0]   nx;
	logic [DW+SH-1:0] n_wide;
	logic [DW+SH-1:0] d_wide;

	mag_t rem_sd [QB+1];
	quo_t nbit_sd [QB+1];
	quo_t quo_sd [QB+1];
	mag_t den_sd [QB+1];
	logic neg_sd [QB+1];
	logic ovf_sd [QB+1];

	// Without a scale the divisor is 1.0, which passes the value through unchanged.
	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= num[DW-1] ? mag_t'(-num) : mag_t'(num);
			if (use_scale) begin
				d_s3   <= scale[DW-1] ? mag_t'(-scale) : mag_t'(scale);
				neg_s3 <= num[DW-1] ^ scale[DW-1];
			end else begin
				d_s3   <= ONE_MAG;
				neg_s3 <= num[DW-1];
			end
		end
	end

	assign nx     = {n_s3, {FB{1'b0}}};
	assign n_wide = {{SH{1'b0}}, n_s3};
	assign d_wide = {d_s3, {SH{1'b0}}};

	// The quotient reaches 2^QB exactly when n >= d * 2^(QB-FB); below that the
	// high part of the shifted numerator is already smaller than the divisor.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_sd[0]  <= mag_t'(nx[NW-1:QB]);
			nbit_sd[0] <= nx[QB-1:0];
			quo_sd[0]  <= '0;
			den_sd[0]  <= d_s3;
			neg_sd[0]  <= neg_s3;
			ovf_sd[0]  <= (n_wide >= d_wide);
		end
	end

	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [DW:0] trial;
		logic        ge;

		assign trial = {rem_sd[i], nbit_sd[i][QB-1]};
		assign ge    = (trial >= {1'b0, den_sd[i]});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[i+1]  <= ge ? mag_t'(trial - {1'b0, den_sd[i]}) : trial[DW-1:0];
				nbit_sd[i+1] <= nbit_sd[i] << 1;
				quo_sd[i+1]  <= {quo_sd[i][QB-2:0], ge};
				den_sd[i+1]  <= den_sd[i];
				neg_sd[i+1]  <= neg_sd[i];
				ovf_sd[i+1]  <= ovf_sd[i];
			end
		end
	end

	assign res = '{neg: neg_sd[QB], ovf: ovf_sd[QB], quo: quo_sd[QB]};

endmodule
`default_nettype wire

// ===== design/hvt_merge.sv =====
`default_nettype none
module hvt_merge (
	input  hvt_pkg::div_res_t  res [hvt_pkg::LANES],
	input  hvt_pkg::ctl_t      ctl,
	output hvt_pkg::out_item_t item
);
	import hvt_pkg::*;

	localparam quo_t  MAG_MIN = quo_t'(1) << (CW - 1);
	localparam quo_t  MAG_MAX = MAG_MIN - quo_t'(1);
	localparam comp_t VAL_MIN = comp_t'(MAG_MIN[CW-1:0]);
	localparam comp_t VAL_MAX = comp_t'(MAG_MAX[CW-1:0]);

	comp_t            vals [LANES];
	logic [LANES-1:0] sat_vec;
	logic [LANES-1:0] keep;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			// The w lane carries no result in point mode; a zero scale clears all.
			keep[k]    = !ctl.zero && ((k < LANES - 1) || !ctl.point);
			sat_vec[k] = keep[k] && (res[k].ovf ||
				(res[k].neg ? (res[k].quo > MAG_MIN) : (res[k].quo > MAG_MAX)));
			if (!keep[k]) begin
				vals[k] = '0;
			end else if (sat_vec[k]) begin
				vals[k] = res[k].neg ? VAL_MIN : VAL_MAX;
			end else begin
				vals[k] = res[k].neg ? comp_t'(-res[k].quo[CW-1:0]) : comp_t'(res[k].quo[CW-1:0]);
			end
		end
		item.out_x      = FIELD_W'(vals[0]);
		item.out_y      = FIELD_W'(vals[1]);
		item.out_z      = FIELD_W'(vals[2]);
		item.out_w      = FIELD_W'(vals[3]);
		item.zero_scale = ctl.zero;
		item.saturated  = |sat_vec;
	end

endmodule
`default_nettype wire
